/* hdl/kvm_pkg.sv */
package kvm_pkg;

    // Fixed widths of the request and response fields
    localparam int FIELD_BITS = 32;
    localparam int COUNT_BITS = 6;

    // Command queue between front and engine
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CW    = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic                  status;
        logic                  found;
        logic [FIELD_BITS-1:0] match_value;
        logic [COUNT_BITS-1:0] removed_count;
        logic                  last;
    } rsp_t;

endpackage

/* hdl/kvm_if.sv */
interface kvm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface kvm_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        found;
    logic [31:0] match_value;
    logic [5:0]  removed_count;
    logic        last;

    modport source (output valid, output status, output found, output match_value,
                    output removed_count, output last, input ready);
    modport sink   (input valid, input status, input found, input match_value,
                    input removed_count, input last, output ready);
endinterface

/* hdl/kvm_front.sv */
// Front end: takes requests, drops unused opcodes, stages commands for the queue
module kvm_front (
    input  logic            clk,
    input  logic            rst_n,
    kvm_req_if.sink         req,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output kvm_pkg::cmd_t   cmd
);

    logic          stage_valid_reg;
    logic          stage_valid_next;
    kvm_pkg::cmd_t stage_cmd_reg;
    kvm_pkg::cmd_t stage_cmd_next;
    logic          keep;
    kvm_pkg::op_t  op_dec;

    // Opcode decode; an unused code is accepted and discarded
    always_comb
    begin
        keep   = 1'b0;
        op_dec = kvm_pkg::OP_INSERT;
        unique case (req.op)
            kvm_pkg::OP_INSERT:
            begin
                keep   = 1'b1;
                op_dec = kvm_pkg::OP_INSERT;
            end
            kvm_pkg::OP_FIND:
            begin
                keep   = 1'b1;
                op_dec = kvm_pkg::OP_FIND;
            end
            kvm_pkg::OP_REMOVE:
            begin
                keep   = 1'b1;
                op_dec = kvm_pkg::OP_REMOVE;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req.ready = !stage_valid_reg || cmd_ready;
    assign cmd_valid = stage_valid_reg;
    assign cmd       = stage_cmd_reg;

    // Stage register
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_cmd_next   = stage_cmd_reg;
        if (req.valid && req.ready)
        begin
            stage_valid_next     = keep;
            stage_cmd_next.op    = op_dec;
            stage_cmd_next.key   = req.key;
            stage_cmd_next.value = req.value;
        end
        else if (cmd_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_cmd_reg <= stage_cmd_next;
    end

endmodule

/* hdl/kvm_cmd_fifo.sv */
// Short command queue between front end and engine
module kvm_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  kvm_pkg::cmd_t   push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output kvm_pkg::cmd_t   pop_cmd
);

    kvm_pkg::cmd_t                 slot_reg [kvm_pkg::FIFO_DEPTH];
    logic [kvm_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [kvm_pkg::FIFO_AW-1:0]   wr_ptr_next;
    logic [kvm_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [kvm_pkg::FIFO_AW-1:0]   rd_ptr_next;
    logic [kvm_pkg::FIFO_CW-1:0]   count_reg;
    logic [kvm_pkg::FIFO_CW-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = count_reg != kvm_pkg::FIFO_CW'(kvm_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/kvm_engine.sv */
// Engine: holds the pair memory, runs insert, find scan and compacting remove
module kvm_engine #(
    parameter int DEPTH      = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  kvm_pkg::cmd_t   cmd,
    kvm_rsp_if.source       rsp
);

    localparam int FB = kvm_pkg::FIELD_BITS;
    localparam int NB = kvm_pkg::COUNT_BITS;
    localparam int KW = (KEY_BITS < FB) ? KEY_BITS : FB;
    localparam int VW = (VALUE_BITS < FB) ? VALUE_BITS : FB;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Pair memory, one write and one registered read port
    logic [KW-1:0] key_mem [DEPTH];
    logic [VW-1:0] val_mem [DEPTH];
    logic [KW-1:0] rd_key_reg;
    logic [VW-1:0] rd_val_reg;

    state_t          state_reg, state_next;
    kvm_pkg::op_t    op_reg, op_next;
    logic [KW-1:0]   key_reg, key_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic [CW-1:0]   kept_reg, kept_next;
    logic            data_valid_reg, data_valid_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [VW-1:0]   pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    kvm_pkg::rsp_t   out_reg, out_next;

    logic            out_free;
    logic            match;
    logic            stall;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [KW-1:0]   wr_key;
    logic [VW-1:0]   wr_val;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   removed;
    logic [CW+NB-1:0] removed_ext;
    logic [VW+FB-1:0] pend_ext;
    logic [KW-1:0]   cmd_key;
    logic [VW-1:0]   cmd_val;

    assign out_free    = !out_valid_reg || rsp.ready;
    assign match       = rd_key_reg == key_reg;
    assign stall       = (op_reg == kvm_pkg::OP_FIND) && data_valid_reg && match
                         && pend_valid_reg && !out_free;
    assign removed     = count_reg - kept_reg;
    assign removed_ext = {{NB{1'b0}}, removed};
    assign pend_ext    = {{FB{1'b0}}, pend_reg};
    assign cmd_key     = cmd.key[KW-1:0];
    assign cmd_val     = cmd.value[VW-1:0];
    assign cmd_ready   = (state_reg == ST_IDLE) && out_free;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.found         = out_reg.found;
    assign rsp.match_value   = out_reg.match_value;
    assign rsp.removed_count = out_reg.removed_count;
    assign rsp.last          = out_reg.last;

    // Control, scan and result sequencing
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        kept_next       = kept_reg;
        data_valid_next = data_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_key          = cmd_key;
        wr_val          = cmd_val;
        rd_en           = 1'b0;
        rd_addr         = scan_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    op_next         = cmd.op;
                    key_next        = cmd_key;
                    scan_next       = '0;
                    kept_next       = '0;
                    data_valid_next = 1'b0;
                    pend_valid_next = 1'b0;
                    unique case (cmd.op)
                        kvm_pkg::OP_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '0;
                            out_next.last  = 1'b1;
                            if (count_reg >= CW'(DEPTH))
                            begin
                                out_next.status = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        kvm_pkg::OP_FIND,
                        kvm_pkg::OP_REMOVE:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    // Issue the next read
                    if (scan_reg < count_reg)
                    begin
                        rd_en           = 1'b1;
                        scan_next       = scan_reg + 1'b1;
                        data_valid_next = 1'b1;
                    end
                    else
                    begin
                        data_valid_next = 1'b0;
                    end
                    // Consume the entry from the registered read
                    if (data_valid_reg)
                    begin
                        if (op_reg == kvm_pkg::OP_FIND)
                        begin
                            if (match)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next       = 1'b1;
                                    out_next             = '0;
                                    out_next.found       = 1'b1;
                                    out_next.match_value = pend_ext[FB-1:0];
                                end
                                pend_valid_next = 1'b1;
                                pend_next       = rd_val_reg;
                            end
                        end
                        else if (!match)
                        begin
                            // Compact survivors toward the front
                            wr_en     = 1'b1;
                            wr_addr   = kept_reg[AW-1:0];
                            wr_key    = rd_key_reg;
                            wr_val    = rd_val_reg;
                            kept_next = kept_reg + 1'b1;
                        end
                    end
                    if (scan_reg >= count_reg && !data_valid_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.last  = 1'b1;
                    if (op_reg == kvm_pkg::OP_FIND)
                    begin
                        out_next.found       = pend_valid_reg;
                        out_next.match_value = pend_valid_reg ? pend_ext[FB-1:0] : '0;
                    end
                    else
                    begin
                        out_next.removed_count = removed_ext[NB-1:0];
                        count_next             = kept_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= kvm_pkg::OP_INSERT;
            key_reg        <= '0;
            count_reg      <= '0;
            scan_reg       <= '0;
            kept_reg       <= '0;
            data_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            kept_reg       <= kept_next;
            data_valid_reg <= data_valid_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    // Pair memory; compaction writes always trail the read address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

endmodule

/* hdl/key_value_multimap_table.sv */
// Unsorted key/value multimap of up to DEPTH pairs kept in insertion order, duplicate
// keys allowed. Insert appends a pair and answers with status high when the table is
// full. Find reads every stored pair through the single memory read port and returns
// one response per matching value, in insertion order, with last on the final one, or
// one response with found low when nothing matches. Remove reads every pair, writes the
// survivors back toward the front in order and answers with the number deleted. Once
// the engine takes a find or remove it stays busy until the scan is done; the scan
// reads the memory one entry per cycle unless a pending find match waits on a held
// response, and back-pressure on the response side holds the engine further. The
// front stage and the queue register each request ahead of the engine.
// Requests with opcode 3 are taken and produce no response. A two-entry command queue
// lets requests be taken while the engine still works or a response waits.
module key_value_multimap_table #(
    parameter int DEPTH      = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    kvm_req_if.sink     req,
    kvm_rsp_if.source   rsp
);

    logic          front_valid;
    logic          front_ready;
    kvm_pkg::cmd_t front_cmd;
    logic          queue_valid;
    logic          queue_ready;
    kvm_pkg::cmd_t queue_cmd;

    kvm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    kvm_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    kvm_engine #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .rsp       (rsp)
    );

endmodule
